FILE: rtl/tea16_pkg.sv
// ----------------------------------------------------------------------------
// tea16_pkg
// Shared types, constants and round-sum helpers for the 16-bit TEA pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tea16_pkg;

  // round count and derived pipeline depth, one stage per half-round
  localparam int ROUNDS    = 32;
  localparam int STAGES    = 2 * ROUNDS;
  localparam int WORD_W    = 16;
  localparam int CFG_IDX_W = 4;

  localparam logic [WORD_W-1:0] DELTA = 16'h9e37;

  typedef logic [WORD_W-1:0] word_t;

  // key register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ZERO  = 4'd0,
    REG_KEY_ONE   = 4'd1,
    REG_KEY_TWO   = 4'd2,
    REG_KEY_THREE = 4'd3
  } key_reg_e;

  // block travelling down the pipeline
  typedef struct packed {
    logic  decrypt;
    word_t h0;
    word_t h1;
  } blk_t;

  // the four key words
  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_t;

  // encrypt sum for round r: (r + 1) * delta, wrapped
  function automatic word_t enc_sum(input int r);
    logic [31:0] p;
    p = 32'(r + 1) * 32'(DELTA);
    return p[WORD_W-1:0];
  endfunction

  // decrypt sum for round r: (ROUNDS - r) * delta, wrapped
  function automatic word_t dec_sum(input int r);
    logic [31:0] p;
    p = 32'(ROUNDS - r) * 32'(DELTA);
    return p[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tea16_block_cipher.sv
// ----------------------------------------------------------------------------
// tea16_block_cipher
// 16-bit-word TEA encrypt/decrypt engine, fully unrolled into a pipeline.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload
//  -------  ---------  ------------------------------------------------------
//  s_*      in         tdata: first_half, second_half; tuser: cmd
//  m_*      out        tdata: result_first, result_second
//  cfg_*    in         key word writes, index 0..3
//
//  One item enters per cycle unless a held output has backed the pipeline
//  up to the input; each of the 2*ROUNDS half-rounds is one register stage.
//  Every stage holds its own valid bit, so a held output stalls only the
//  occupied stages and empty slots fill up behind it.
//  Synchronous reset clears the valid bits and sets the key words to zero.
//
`default_nettype none

module tea16_block_cipher
  import tea16_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // slave side
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [31:0]          s_tdata,   // [15:0] first_half, [31:16] second_half
  input  wire logic                 s_tuser,   // [0] cmd
  // master side
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [31:0]               m_tdata,   // [15:0] result_first, [31:16] result_second
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  key_t key;
  blk_t stage_blk   [0:STAGES];
  logic stage_valid [0:STAGES];
  logic stage_ready [0:STAGES];

  tea16_key_regs u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  // input side of the pipeline
  assign stage_valid[0]      = s_tvalid;
  assign s_tready            = stage_ready[0];
  assign stage_blk[0].decrypt = s_tuser;
  assign stage_blk[0].h0      = s_tdata[15:0];
  assign stage_blk[0].h1      = s_tdata[31:16];

  // one stage per half-round
  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    tea16_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .sum_enc   (enc_sum(j / 2)),
      .sum_dec   (dec_sum(j / 2)),
      .odd_half  (1'((j % 2) == 1)),
      .in_valid  (stage_valid[j]),
      .in_ready  (stage_ready[j]),
      .in_blk    (stage_blk[j]),
      .out_valid (stage_valid[j+1]),
      .out_ready (stage_ready[j+1]),
      .out_blk   (stage_blk[j+1])
    );
  end

  // output side, the last stage register drives the port
  assign stage_ready[STAGES] = m_tready;
  assign m_tvalid            = stage_valid[STAGES];
  assign m_tdata             = {stage_blk[STAGES].h1, stage_blk[STAGES].h0};

endmodule

`default_nettype wire

FILE: rtl/tea16_key_regs.sv
// ----------------------------------------------------------------------------
// tea16_key_regs
// Key word registers written through the plain configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module tea16_key_regs
  import tea16_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output key_t                      key
);

  // decode the index, writes beyond the last key are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_ZERO:  key.k0 <= cfg_data;
        REG_KEY_ONE:   key.k1 <= cfg_data;
        REG_KEY_TWO:   key.k2 <= cfg_data;
        REG_KEY_THREE: key.k3 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tea16_stage.sv
// ----------------------------------------------------------------------------
// tea16_stage
// One half-round of the cipher with its own valid bit and stall handling.
// ----------------------------------------------------------------------------
`default_nettype none

module tea16_stage
  import tea16_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire key_t  key,
  input  wire word_t sum_enc,
  input  wire word_t sum_dec,
  input  wire logic  odd_half,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire blk_t  in_blk,
  output logic       out_valid,
  input  wire logic  out_ready,
  output blk_t       out_blk
);

  function automatic word_t mix(input word_t x, input word_t s,
                                input word_t ka, input word_t kb);
    word_t a;
    word_t b;
    word_t c;
    a = (x << 4) + ka;
    b = x + s;
    c = (x >> 5) + kb;
    return a ^ b ^ c;
  endfunction

  blk_t  blk_next;
  word_t mix_first;
  word_t mix_second;

  // encrypt: first half-round mixes the second half, second half-round the first; decrypt swaps the order
  always_comb begin
    blk_next   = in_blk;
    mix_first  = '0;
    mix_second = '0;
    if (!in_blk.decrypt) begin
      if (!odd_half) begin
        mix_first  = mix(in_blk.h1, sum_enc, key.k0, key.k1);
        blk_next.h0 = in_blk.h0 + mix_first;
      end else begin
        mix_second = mix(in_blk.h0, sum_enc, key.k2, key.k3);
        blk_next.h1 = in_blk.h1 + mix_second;
      end
    end else begin
      if (!odd_half) begin
        mix_second = mix(in_blk.h0, sum_dec, key.k2, key.k3);
        blk_next.h1 = in_blk.h1 - mix_second;
      end else begin
        mix_first  = mix(in_blk.h1, sum_dec, key.k0, key.k1);
        blk_next.h0 = in_blk.h0 - mix_first;
      end
    end
  end

  // stage moves when empty or when the next stage takes its item
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_blk <= blk_next;
    end
  end

endmodule

`default_nettype wire
